>>> hdl/json_delimiter_scanner_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimiter scanner
// Concurrent checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef JSON_DELIMITER_SCANNER_UNIT_MACROS_SVH
`define JSON_DELIMITER_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication.
`define JDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jds_pkg.sv
// ----------------------------------------------------------------------------
// jds_pkg
// Types and constants shared by the delimiter scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jds_pkg;

    localparam int STACK_DEPTH   = 64;
    localparam int POSITION_BITS = 16;
    localparam int DEPTH_W       = $clog2(STACK_DEPTH + 1);
    localparam int CHAR_W        = 8;
    localparam int START_W       = 16;
    localparam int OFS_W         = 16;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_QUOTE        = 8'h22;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;

    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd44;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 8'd1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_END       = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [POSITION_BITS-1:0] position;
    } t_out_item;

    // Stack shift control: push moves every entry one cell deeper.
    typedef struct packed {
        logic push;
        logic pop;
        logic push_bit;  // 1 = square, 0 = curly
    } t_stack_ctl;

endpackage

`default_nettype wire

>>> hdl/jds_cell.sv
// ----------------------------------------------------------------------------
// jds_cell
// One entry of the bracket stack; takes its upper or lower neighbor's bit.
// ----------------------------------------------------------------------------
`default_nettype none

module jds_cell import jds_pkg::*; (
    input  wire logic       i_clk,
    input  wire t_stack_ctl i_ctl,
    input  wire logic       i_upper,
    input  wire logic       i_lower,
    output logic            o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.push) begin
            n_bit = i_upper;
        end else if (i_ctl.pop) begin
            n_bit = i_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

>>> hdl/jds_stack.sv
// ----------------------------------------------------------------------------
// jds_stack
// Bracket stack as a chain of cells; cell 0 always holds the top entry.
// ----------------------------------------------------------------------------
`default_nettype none

module jds_stack import jds_pkg::*; (
    input  wire logic       i_clk,
    input  wire t_stack_ctl i_ctl,
    output logic            o_top
);

    logic [STACK_DEPTH-1:0] w_bits;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic w_upper;
        logic w_lower;

        if (g == 0) begin : g_head
            assign w_upper = i_ctl.push_bit;
        end else begin : g_body
            assign w_upper = w_bits[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_lower = 1'b0;
        end else begin : g_inner
            assign w_lower = w_bits[g+1];
        end

        jds_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_upper (w_upper),
            .i_lower (w_lower),
            .o_bit   (w_bits[g])
        );
    end

    assign o_top = w_bits[0];

endmodule

`default_nettype wire

>>> hdl/json_delimiter_scanner_unit.sv
// A result item is registered in the output register when the byte that decides it is
// accepted. Throughput: one byte per cycle while the output is not stalled, set by the shift-stack chain
// (each byte reads only cell 0) and the single output register.
// Reset (synchronous, active low) clears depth, quote, offset, decided and the output
// valid, and loads delimiter 44 and start position 0; stack cells are not cleared.
// ----------------------------------------------------------------------------
// json_delimiter_scanner_unit
// Finds the first delimiter byte at nesting depth zero, or reports a bracket
// error, stack overflow or end of message without a find.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_delimiter_scanner_unit_macros.svh"

module json_delimiter_scanner_unit import jds_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // byte input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    // result output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = (POSITION_BITS > OFS_W) ? POSITION_BITS + 1 : OFS_W + 1;
    localparam logic [SUM_W-1:0] POS_MAX =
        {{(SUM_W-POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [OFS_W-1:0]   OFS_MAX    = {OFS_W{1'b1}};

    logic [CHAR_W-1:0]  r_delim;
    logic [START_W-1:0] r_start;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    logic               r_in_quote;
    logic               n_in_quote;
    logic [OFS_W-1:0]   r_offset;
    logic               r_decided;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_top;
    logic               w_err;
    t_status            w_err_status;
    logic               w_found;
    logic               w_hit;
    logic               w_push;
    logic               w_pop;
    logic [CHAR_W-1:0]  w_char;
    logic [SUM_W-1:0]   w_sum;
    logic [POSITION_BITS-1:0] w_position;
    t_stack_ctl         w_stack_ctl;

    assign w_char    = i_in_item.character;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = r_out_valid && i_out_ready;

    // ---- scan decision for the byte on the input ----
    always_comb begin
        n_depth      = r_depth;
        n_in_quote   = r_in_quote;
        w_push       = 1'b0;
        w_pop        = 1'b0;
        w_err        = 1'b0;
        w_err_status = ST_UNMATCHED;
        // inside quotes only a quote does anything
        if (!(r_in_quote && w_char != CH_QUOTE)) begin
            if (w_char == CH_OPEN_CURLY || w_char == CH_OPEN_SQUARE) begin
                if (r_depth == DEPTH_FULL) begin
                    w_err        = 1'b1;
                    w_err_status = ST_OVERFLOW;
                end else begin
                    w_push  = 1'b1;
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end else if (w_char == CH_QUOTE) begin
                n_in_quote = !r_in_quote;
            end else if (w_char == CH_CLOSE_CURLY || w_char == CH_CLOSE_SQUARE) begin
                if (r_depth == '0 || w_top != (w_char == CH_CLOSE_SQUARE)) begin
                    w_err = 1'b1;
                end else begin
                    w_pop   = 1'b1;
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
        end
        w_found = !w_err && n_depth == '0 && !n_in_quote && w_char == r_delim;
        w_hit   = w_err || w_found;
    end

    assign w_sum = SUM_W'(r_start) + SUM_W'(r_offset);
    assign w_position = (w_sum > POS_MAX) ? {POSITION_BITS{1'b1}}
                                          : w_sum[POSITION_BITS-1:0];

    assign w_stack_ctl.push     = w_in_acc && !r_decided && w_push;
    assign w_stack_ctl.pop      = w_in_acc && !r_decided && w_pop;
    assign w_stack_ctl.push_bit = (w_char == CH_OPEN_SQUARE);

    jds_stack u_stack (
        .i_clk (i_clk),
        .i_ctl (w_stack_ctl),
        .o_top (w_top)
    );

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= DELIM_RESET;
            r_start     <= '0;
            r_depth     <= '0;
            r_in_quote  <= 1'b0;
            r_offset    <= '0;
            r_decided   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DELIMITER: r_delim <= i_cfg_data[CHAR_W-1:0];
                    CFG_START_POS: r_start <= i_cfg_data[START_W-1:0];
                    default: ;
                endcase
            end
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                if (!r_decided && (w_hit || i_in_item.last)) begin
                    r_out_valid <= 1'b1;
                end
                if (i_in_item.last) begin
                    r_depth    <= '0;
                    r_in_quote <= 1'b0;
                    r_offset   <= '0;
                    r_decided  <= 1'b0;
                end else begin
                    if (!r_decided) begin
                        r_depth    <= n_depth;
                        r_in_quote <= n_in_quote;
                        r_decided  <= w_hit;
                    end
                    if (r_offset != OFS_MAX) begin
                        r_offset <= r_offset + OFS_W'(1);
                    end
                end
            end
        end
    end

    // ---- result payload ----
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !r_decided) begin
            if (w_hit) begin
                r_out_item.status   <= w_err ? w_err_status : ST_FOUND;
                r_out_item.position <= w_position;
            end else if (i_in_item.last) begin
                r_out_item.status   <= ST_END;
                r_out_item.position <= '0;
            end
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // ---- checks ----
    `JDS_ASSERT_IMPL(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_FULL, "depth beyond stack size")
    `JDS_ASSERT_NEXT(a_msg_reset, i_clk, i_rst_n, w_in_acc && i_in_item.last, r_depth == '0 && !r_in_quote && !r_decided && r_offset == '0, "message state not cleared after last item")
    `JDS_ASSERT_NEXT(a_silent_after_decide, i_clk, i_rst_n, w_in_acc && r_decided && !i_in_item.last && !r_out_valid, !r_out_valid, "result after decision")
    `JDS_ASSERT_IMPL(a_no_shift_when_decided, i_clk, i_rst_n, r_decided, !w_stack_ctl.push && !w_stack_ctl.pop, "stack moved after decision")

endmodule

`default_nettype wire
